// ===== design/catmull_rom_spline_evaluator_defines.svh =====
// Assertion macros for the spline evaluator RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef CATMULL_ROM_SPLINE_EVALUATOR_DEFINES_SVH
`define CATMULL_ROM_SPLINE_EVALUATOR_DEFINES_SVH

// Property checked on every rising clock edge outside reset.
`define CRS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition that must never be true outside reset.
`define CRS_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ===== design/crs_pkg.sv =====
// Shared types and constants for the Catmull-Rom spline evaluator.
// No dependencies.
package crs_pkg;

  localparam int MAX_POINTS_DEF = 64;
  localparam int FRAC_BITS      = 16;
  localparam int T_W            = FRAC_BITS + 1;
  localparam int COORD_W        = 32;
  localparam int CNT_REG_W      = 7;
  localparam int SLOT_W         = 6;
  localparam int IDX_MAX_W      = 12;
  localparam int ACC_W          = 38;
  localparam logic [T_W-1:0] T_ONE = T_W'(1 << FRAC_BITS);
  localparam logic [CNT_REG_W-1:0] POINT_COUNT_RST = CNT_REG_W'(4);

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_EVAL = 1'b1
  } cmd_t;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } vec_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [SLOT_W-1:0] point_index;
    coord_t            point_x;
    coord_t            point_y;
    coord_t            point_z;
    logic [T_W-1:0]    t_param;
  } in_item_t;

  typedef struct packed {
    coord_t out_x;
    coord_t out_y;
    coord_t out_z;
  } out_item_t;

  // Classified job as held in the queue; for a load, i0 is the write slot.
  typedef struct packed {
    cmd_t                 kind;
    logic [T_W-1:0]       frac;
    logic [IDX_MAX_W-1:0] i0;
    logic [IDX_MAX_W-1:0] i1;
    logic [IDX_MAX_W-1:0] i2;
    logic [IDX_MAX_W-1:0] i3;
    vec_t                 pt;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } head_t;

  typedef struct packed {
    logic           valid;
    logic [T_W-1:0] frac;
    vec_t           p0;
    vec_t           p1;
    vec_t           p2;
    vec_t           p3;
  } hin_t;

endpackage

// ===== design/crs_front.sv =====
// Front end: point_count register, item classification and two-entry job queue.
// Depends on crs_pkg.
module crs_front
  import crs_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  in_item_t             item,
  input  logic                 cfg_we,
  input  logic [CNT_REG_W-1:0] cfg_data,
  output head_t                head,
  input  logic                 pop
);

  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int SW    = T_W + CNT_W;

  logic [CNT_REG_W-1:0] point_count;
  job_t                 q_mem [2];
  logic                 wptr, rptr;
  logic [1:0]           count, count_next;

  logic [CNT_W-1:0] n, d, seg, seg_m1;
  logic [CNT_W:0]   seg_raw, seg_p1, seg_p2;
  logic [T_W-1:0]   tc, frac;
  logic [SW-1:0]    scaled;
  logic             slot_ok, push;
  job_t             job_new;

  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= POINT_COUNT_RST;
    end else if (cfg_we) begin
      point_count <= cfg_data;
    end
  end

  // Segment selection
  always_comb begin
    if (point_count < CNT_REG_W'(4)) begin
      n = CNT_W'(4);
    end else if (32'(point_count) > 32'(MAX_POINTS)) begin
      n = CNT_W'(MAX_POINTS);
    end else begin
      n = CNT_W'(point_count);
    end
    d = n - CNT_W'(1);
    tc = (item.t_param > T_ONE) ? T_ONE : item.t_param;
    scaled = SW'(tc) * SW'(d);
    seg_raw = scaled[SW-1:FRAC_BITS];
    if (seg_raw >= {1'b0, d}) begin
      seg  = d - CNT_W'(1);
      frac = T_ONE;
    end else begin
      seg  = seg_raw[CNT_W-1:0];
      frac = {1'b0, scaled[FRAC_BITS-1:0]};
    end
    seg_m1 = (seg == '0) ? '0 : seg - CNT_W'(1);
    seg_p1 = {1'b0, seg} + (CNT_W+1)'(1);
    seg_p2 = {1'b0, seg} + (CNT_W+1)'(2);
    slot_ok = 32'(item.point_index) < 32'(MAX_POINTS);

    job_new.kind = item.cmd;
    job_new.pt   = '{x: item.point_x, y: item.point_y, z: item.point_z};
    if (item.cmd == CMD_EVAL) begin
      job_new.frac = frac;
      job_new.i0   = IDX_MAX_W'(seg_m1);
      job_new.i1   = IDX_MAX_W'(seg);
      job_new.i2   = IDX_MAX_W'(seg_p1);
      job_new.i3   = (seg_p2 >= {1'b0, n}) ? IDX_MAX_W'(seg_p1) : IDX_MAX_W'(seg_p2);
    end else begin
      job_new.frac = '0;
      job_new.i0   = IDX_MAX_W'(item.point_index);
      job_new.i1   = '0;
      job_new.i2   = '0;
      job_new.i3   = '0;
    end
  end

  // Out-of-range loads are dropped here and never reach the queue.
  assign busy = (count == 2'd2);
  assign push = start && !busy && ((item.cmd == CMD_EVAL) || slot_ok);
  assign count_next = count + {1'b0, push} - {1'b0, pop};

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      wptr  <= 1'b0;
      rptr  <= 1'b0;
    end else begin
      count <= count_next;
      if (push) wptr <= !wptr;
      if (pop)  rptr <= !rptr;
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_mem[wptr] <= job_new;
  end

  assign head.valid = (count != 2'd0);
  assign head.job   = q_mem[rptr];

endmodule

// ===== design/crs_fetch.sv =====
// Back end fetch: point store and the four-read sequencer per evaluation.
// Depends on crs_pkg and catmull_rom_spline_evaluator_defines.svh.
`include "catmull_rom_spline_evaluator_defines.svh"
module crs_fetch
  import crs_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic  clk,
  input  logic  rst,
  input  head_t head,
  output logic  pop,
  output hin_t  hin
);

  localparam int IDX_W = $clog2(MAX_POINTS);

  vec_t mem [MAX_POINTS];

  logic             active;
  logic [1:0]       cnt;
  logic [IDX_W-1:0] cur_idx [4];
  logic [T_W-1:0]   cur_f;

  logic             last, take_eval, take_load, re;
  logic [IDX_W-1:0] addr;
  logic [1:0]       slot;
  logic [T_W-1:0]   f_issue;

  logic           rd_v;
  logic [1:0]     rd_slot;
  logic [T_W-1:0] rd_f;
  vec_t           rd_q;
  vec_t           hold [3];

  // The taking cycle issues the first read, so a new evaluation can start
  // the cycle after the fourth read of the previous one.
  assign last      = active && (cnt == 2'd3);
  assign take_eval = head.valid && (head.job.kind == CMD_EVAL) && !active;
  assign take_load = head.valid && (head.job.kind == CMD_LOAD) && !active;
  assign pop       = take_eval || take_load;

  // One port: a load writes only while no read is in flight.
  always_comb begin
    if (pop) begin
      addr    = head.job.i0[IDX_W-1:0];
      slot    = 2'd0;
      f_issue = head.job.frac;
    end else begin
      addr    = cur_idx[cnt];
      slot    = cnt;
      f_issue = cur_f;
    end
    re = take_eval || (active && !pop);
  end

  always_ff @(posedge clk) begin
    if (take_load) mem[addr] <= head.job.pt;
    if (re) rd_q <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      cnt    <= '0;
      rd_v   <= 1'b0;
    end else begin
      rd_v <= re;
      if (take_eval) begin
        active <= 1'b1;
        cnt    <= 2'd1;
      end else if (active) begin
        cnt <= cnt + 2'd1;
        if (last) active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_eval) begin
      cur_idx[0] <= head.job.i0[IDX_W-1:0];
      cur_idx[1] <= head.job.i1[IDX_W-1:0];
      cur_idx[2] <= head.job.i2[IDX_W-1:0];
      cur_idx[3] <= head.job.i3[IDX_W-1:0];
      cur_f      <= head.job.frac;
    end
    rd_slot <= slot;
    rd_f    <= f_issue;
    if (rd_v && (rd_slot != 2'd3)) hold[rd_slot] <= rd_q;
  end

  assign hin.valid = rd_v && (rd_slot == 2'd3);
  assign hin.frac  = rd_f;
  assign hin.p0    = hold[0];
  assign hin.p1    = hold[1];
  assign hin.p2    = hold[2];
  assign hin.p3    = rd_q;

  `CRS_ASSERT(a_last_read, last |=> (rd_v && (rd_slot == 2'd3)), "fourth read missing")
  `CRS_ASSERT(a_eval_start, take_eval |=> (active && (cnt == 2'd1)), "sequencer did not start")
  `CRS_NEVER(a_port_clash, take_load && active, "store write during read sequence")

endmodule

// ===== design/crs_horner.sv =====
// Back end arithmetic: basis coefficients, three Horner steps and saturation.
// Depends on crs_pkg.
module crs_horner
  import crs_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  hin_t      hin,
  output logic      done,
  output out_item_t result
);

  localparam int PW = ACC_W + T_W + 1;

  typedef logic signed [ACC_W-1:0] acc_t;

  acc_t q0 [3], q1 [3], q2 [3], q3 [3];
  acc_t e3 [3], e2 [3], e1 [3], e0 [3];
  acc_t a1 [3], a2 [3], a3 [3];
  acc_t c1_1 [3], c1_0 [3], c2_0 [3];
  acc_t n1 [3], n2 [3], n3 [3], hh [3];
  coord_t sat [3];
  coord_t res [3];
  logic [T_W-1:0] f0, f1, f2;
  logic [4:0] vld;

  function automatic acc_t hstep(acc_t a, logic [T_W-1:0] f, acc_t e);
    logic signed [PW-1:0] prod;
    logic signed [PW-1:0] sh;
    prod = PW'(a) * $signed({1'b0, f});
    sh   = prod >>> FRAC_BITS;
    return sh[ACC_W-1:0] + e;
  endfunction

  always_comb begin
    q0[0] = ACC_W'(hin.p0.x); q0[1] = ACC_W'(hin.p0.y); q0[2] = ACC_W'(hin.p0.z);
    q1[0] = ACC_W'(hin.p1.x); q1[1] = ACC_W'(hin.p1.y); q1[2] = ACC_W'(hin.p1.z);
    q2[0] = ACC_W'(hin.p2.x); q2[1] = ACC_W'(hin.p2.y); q2[2] = ACC_W'(hin.p2.z);
    q3[0] = ACC_W'(hin.p3.x); q3[1] = ACC_W'(hin.p3.y); q3[2] = ACC_W'(hin.p3.z);
    for (int k = 0; k < 3; k++) begin
      n1[k] = hstep(e3[k], f0, e2[k]);
      n2[k] = hstep(a1[k], f1, c1_1[k]);
      n3[k] = hstep(a2[k], f2, c2_0[k]);
      hh[k] = a3[k] >>> 1;
      // fits when all bits above bit 31 match the sign
      if (&hh[k][ACC_W-1:COORD_W-1] || ~|hh[k][ACC_W-1:COORD_W-1]) begin
        sat[k] = hh[k][COORD_W-1:0];
      end else if (hh[k][ACC_W-1]) begin
        sat[k] = {1'b1, {(COORD_W-1){1'b0}}};
      end else begin
        sat[k] = {1'b0, {(COORD_W-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      e3[k]   <= -q0[k] + ACC_W'(3) * q1[k] - ACC_W'(3) * q2[k] + q3[k];
      e2[k]   <= ACC_W'(2) * q0[k] - ACC_W'(5) * q1[k] + ACC_W'(4) * q2[k] - q3[k];
      e1[k]   <= q2[k] - q0[k];
      e0[k]   <= ACC_W'(2) * q1[k];
      a1[k]   <= n1[k];
      c1_1[k] <= e1[k];
      c1_0[k] <= e0[k];
      a2[k]   <= n2[k];
      c2_0[k] <= c1_0[k];
      a3[k]   <= n3[k];
      res[k]  <= sat[k];
    end
    f0 <= hin.frac;
    f1 <= f0;
    f2 <= f1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[3:0], hin.valid};
    end
  end

  assign done          = vld[4];
  assign result.out_x  = res[0];
  assign result.out_y  = res[1];
  assign result.out_z  = res[2];

endmodule

// ===== design/catmull_rom_spline_evaluator.sv =====
// Uniform Catmull-Rom spline evaluator, top level.
// An accepted evaluate passes the job queue, four point-store reads and the arithmetic pipeline before done.
// Each evaluate makes four reads of the single-port point store, and the next one waits for the fourth;
// a load also uses that port. Two queued items may wait, busy rises when both are held.
// Reset (synchronous, rst high) empties the queue and pipeline and sets point_count to 4;
// point storage is not cleared. Results are strobed on done for one cycle; no back-pressure.
module catmull_rom_spline_evaluator
  import crs_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  in_item_t             item,
  input  logic                 cfg_we,
  input  logic [CNT_REG_W-1:0] cfg_data,
  output logic                 done,
  output out_item_t            result
);

  // Front: classifies each item into a load or an evaluation with its four
  // point indices and local fraction, then queues it.
  head_t head;
  logic  pop;
  hin_t  hin;

  crs_front #(.MAX_POINTS(MAX_POINTS)) u_front (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .item     (item),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .head     (head),
    .pop      (pop)
  );

  // Back, first half: store writes and the four point reads per evaluation.
  crs_fetch #(.MAX_POINTS(MAX_POINTS)) u_fetch (
    .clk  (clk),
    .rst  (rst),
    .head (head),
    .pop  (pop),
    .hin  (hin)
  );

  // Back, second half: cubic per coordinate, pipelined, one item per cycle capacity.
  crs_horner u_horner (
    .clk    (clk),
    .rst    (rst),
    .hin    (hin),
    .done   (done),
    .result (result)
  );

endmodule

// ===== test/tb.sv =====
// Testbench for the Catmull-Rom spline evaluator: loads points, evaluates
// curves and checks each strobed result against a local spline predictor.
// Depends on crs_pkg and the catmull_rom_spline_evaluator RTL.
`timescale 1ns / 100ps

module tb;
  import crs_pkg::*;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      start = 1'b0;
  logic      busy;
  in_item_t  item = '0;
  logic      cfg_we = 1'b0;
  logic [CNT_REG_W-1:0] cfg_data = '0;
  logic      done;
  out_item_t result;

  catmull_rom_spline_evaluator uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .cfg_we(cfg_we), .cfg_data(cfg_data), .done(done), .result(result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Local copy of the point store and count register.
  logic [31:0] xs [64];
  logic [31:0] ys [64];
  logic [31:0] zs [64];
  int unsigned count_reg = 4;

  in_item_t  pending_items[$];
  out_item_t expected_pts[$];
  int        errors = 0;
  longint    cycles = 0;
  int        gap_left = 0;
  logic      took = 1'b0;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("error: %s got %h want %h", what, got, want);
    errors++;
  endtask

  function automatic longint floor_div(input longint v, input int s);
    return v >>> s;
  endfunction

  function automatic logic [31:0] spline_coord(input logic [31:0] a0, input logic [31:0] a1,
      input logic [31:0] a2, input logic [31:0] a3, input longint f);
    longint p0, p1, p2, p3, e3, e2, e1, e0, a;
    p0 = longint'($signed(a0)); p1 = longint'($signed(a1));
    p2 = longint'($signed(a2)); p3 = longint'($signed(a3));
    e3 = -p0 + 3 * p1 - 3 * p2 + p3;
    e2 = 2 * p0 - 5 * p1 + 4 * p2 - p3;
    e1 = p2 - p0;
    e0 = 2 * p1;
    a = e3;
    a = floor_div(a * f, FRAC_BITS) + e2;
    a = floor_div(a * f, FRAC_BITS) + e1;
    a = floor_div(a * f, FRAC_BITS) + e0;
    a = floor_div(a, 1);
    if (a > 64'sd2147483647) a = 64'sd2147483647;
    if (a < -64'sd2147483648) a = -64'sd2147483648;
    return a[31:0];
  endfunction

  // Predict the outcome of one accepted item.
  task automatic predict_spline(input in_item_t it);
    int unsigned n, d, seg, i0, i3;
    longint unsigned t, scaled;
    longint f;
    out_item_t r;
    if (it.cmd == CMD_LOAD) begin
      xs[it.point_index] = it.point_x;
      ys[it.point_index] = it.point_y;
      zs[it.point_index] = it.point_z;
    end else begin
      n = count_reg < 4 ? 4 : (count_reg > 64 ? 64 : count_reg);
      d = n - 1;
      t = it.t_param > T_ONE ? 64'(T_ONE) : 64'(it.t_param);
      scaled = t * d;
      seg = 32'(scaled >> FRAC_BITS);
      f = longint'(scaled & 64'hFFFF);
      if (seg >= d) begin
        seg = d - 1;
        f = 65536;
      end
      i0 = seg == 0 ? 0 : seg - 1;
      i3 = seg + 2 >= n ? seg + 1 : seg + 2;
      r.out_x = spline_coord(xs[i0], xs[seg], xs[seg+1], xs[i3], f);
      r.out_y = spline_coord(ys[i0], ys[seg], ys[seg+1], ys[i3], f);
      r.out_z = spline_coord(zs[i0], zs[seg], zs[seg+1], zs[i3], f);
      expected_pts.push_back(r);
    end
  endtask

  function automatic int pick_gap();
    int k;
    k = $urandom_range(0, 99);
    if (k < 50) return 0;
    if (k < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Driver: changes inputs on the falling edge; acceptance is the value of
  // start/busy captured by the monitor at the preceding rising edge.
  logic hold_off = 1'b0;
  logic burst_mode = 1'b0;
  always @(negedge clk) begin
    if (!rst) begin
      if (took) begin
        predict_spline(item);
        void'(pending_items.pop_front());
        gap_left = burst_mode ? 0 : pick_gap();
      end else if (!start && gap_left > 0) begin
        gap_left--;
      end
      if (pending_items.size() > 0 && gap_left == 0 && !hold_off) begin
        item <= pending_items[0];
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: sample acceptance and results at the rising edge.
  always @(posedge clk) begin
    out_item_t want;
    cycles <= cycles + 1;
    took <= !rst && start && !busy;
    if (!rst && done) begin
      if (expected_pts.size() == 0) begin
        report("unexpected result", result.out_x, 32'h0);
      end else begin
        want = expected_pts.pop_front();
        if (result.out_x !== want.out_x) report("out_x", result.out_x, want.out_x);
        if (result.out_y !== want.out_y) report("out_y", result.out_y, want.out_y);
        if (result.out_z !== want.out_z) report("out_z", result.out_z, want.out_z);
      end
    end
    if (cycles > 400000) begin
      $display("catmull_rom_spline_evaluator: mismatch");
      $finish;
    end
  end

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 7))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return 32'h0;
      3: return 32'hFFFFFFFF;
      4: return $urandom();
      default: return 32'($signed($urandom_range(0, 32'h01FFFFFF)) - 32'sh00FFFFFF);
    endcase
  endfunction

  function automatic in_item_t load_item(input int slot);
    in_item_t it;
    it = '0;
    it.cmd = CMD_LOAD;
    it.point_index = SLOT_W'(slot);
    it.point_x = rand_coord();
    it.point_y = rand_coord();
    it.point_z = rand_coord();
    it.t_param = T_W'($urandom());
    return it;
  endfunction

  function automatic in_item_t eval_item(input logic [T_W-1:0] t);
    in_item_t it;
    it = '0;
    it.cmd = CMD_EVAL;
    it.point_index = SLOT_W'($urandom());
    it.point_x = $urandom();
    it.point_y = $urandom();
    it.point_z = $urandom();
    it.t_param = t;
    return it;
  endfunction

  function automatic logic [T_W-1:0] rand_t();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return T_ONE;
      2: return T_W'($urandom_range(T_ONE + 1, 17'h1FFFF));
      default: return T_W'($urandom_range(0, T_ONE));
    endcase
  endfunction

  // Wait until the block has drained, then let the pipeline settle.
  task automatic drain();
    while (pending_items.size() > 0 || start) @(posedge clk);
    while (expected_pts.size() > 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_count(input int value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_data <= CNT_REG_W'(value);
    @(negedge clk);
    cfg_we <= 1'b0;
    count_reg = value;
  endtask

  initial begin
    int settings[8] = '{4, 64, 2, 127, 5, 17, 0, 33};
    int n;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: default count of four, fill slots 0..3, extremes of t.
    for (int s = 0; s < 4; s++) pending_items.push_back(load_item(s));
    pending_items.push_back(eval_item(0));
    pending_items.push_back(eval_item(T_ONE));
    pending_items.push_back(eval_item(17'h1FFFF));
    pending_items.push_back(eval_item(T_W'(T_ONE / 3)));
    pending_items.push_back(eval_item(T_ONE - 1));
    pending_items.push_back(eval_item(1));
    drain();

    // Fill the whole store once so that any count reads written entries.
    for (int s = 0; s < 64; s++) pending_items.push_back(load_item(s));
    drain();

    foreach (settings[k]) begin
      write_count(settings[k]);
      n = settings[k] < 4 ? 4 : (settings[k] > 64 ? 64 : settings[k]);
      burst_mode = (k % 3 == 1);
      for (int i = 0; i < 150; i++) begin
        if ($urandom_range(0, 3) == 0)
          pending_items.push_back(load_item($urandom_range(0, 63)));
        else
          pending_items.push_back(eval_item(rand_t()));
      end
      // Sender holds off until every outstanding result is in.
      if (k == 2) begin
        while (pending_items.size() > 75) @(posedge clk);
        hold_off = 1'b1;
        while (start) @(posedge clk);
        while (expected_pts.size() > 0) @(posedge clk);
        hold_off = 1'b0;
      end
      if (n == 64) pending_items.push_back(eval_item(T_ONE));
      drain();
    end
    drain();

    if (errors == 0) begin
      $display("catmull_rom_spline_evaluator: match");
    end else begin
      $display("catmull_rom_spline_evaluator: mismatch");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+design
design/crs_pkg.sv
design/crs_front.sv
design/crs_fetch.sv
design/crs_horner.sv
design/catmull_rom_spline_evaluator.sv
test/tb.sv
